FILE: design/fpcr_pkg.sv
// Package for the fixed-point cube root: widths, status codes and the pipeline word.
// Used by fpcr_stage and fixed_point_cube_root; depends on nothing.
package fpcr_pkg;

    localparam int unsigned DATA_BITS  = 32;
    localparam int unsigned SCALE_SHIFT = 16;
    localparam int unsigned N_BITS     = 2 * DATA_BITS;
    localparam int unsigned ROOT_BITS  = (N_BITS + 2) / 3;
    localparam int unsigned R2_BITS    = 2 * ROOT_BITS;
    localparam int unsigned R3_BITS    = 3 * ROOT_BITS;
    localparam int unsigned CUBE_BITS  = R3_BITS + 2;
    localparam int unsigned LATENCY    = ROOT_BITS + 2;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_NAN = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    typedef struct packed {
        logic                   valid;
        logic                   pass;
        logic                   neg;
        logic [1:0]             status;
        logic [DATA_BITS-1:0]   pass_val;
        logic [N_BITS-1:0]      n;
        logic [ROOT_BITS-1:0]   r;
        logic [R2_BITS-1:0]     r2;
        logic [R3_BITS-1:0]     r3;
    } t_work;

endpackage

FILE: design/fpcr_stage.sv
// One root bit of the cube root pipeline: trial cube by shifted adds, compare, register.
// Depends on fpcr_pkg.
module fpcr_stage #(
    parameter int unsigned BIT = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fpcr_pkg::t_work i_st,
    output fpcr_pkg::t_work o_st
);
    import fpcr_pkg::*;

    logic [CUBE_BITS-1:0] t_r;
    logic [CUBE_BITS-1:0] t_r2;
    logic [CUBE_BITS-1:0] t_cube;
    logic                 t_keep;
    t_work                n_st;
    t_work                r_st;

    // The candidate cube is (r + 2^b)^3 = r^3 + 3 r^2 2^b + 3 r 2^2b + 2^3b.
    always_comb begin
        t_r    = CUBE_BITS'(i_st.r);
        t_r2   = CUBE_BITS'(i_st.r2);
        t_cube = CUBE_BITS'(i_st.r3) + ((t_r2 + (t_r2 << 1)) << BIT)
               + ((t_r + (t_r << 1)) << (2 * BIT)) + (CUBE_BITS'(1) << (3 * BIT));
        t_keep = t_cube <= CUBE_BITS'(i_st.n);
        n_st   = i_st;
        if (t_keep) begin
            n_st.r  = i_st.r | (ROOT_BITS'(1) << BIT);
            n_st.r2 = i_st.r2 + (R2_BITS'(i_st.r) << (BIT + 1))
                    + (R2_BITS'(1) << (2 * BIT));
            n_st.r3 = t_cube[R3_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.valid <= 1'b0;
        end else begin
            r_st.valid <= n_st.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st.pass     <= n_st.pass;
        r_st.neg      <= n_st.neg;
        r_st.status   <= n_st.status;
        r_st.pass_val <= n_st.pass_val;
        r_st.n        <= n_st.n;
        r_st.r        <= n_st.r;
        r_st.r2       <= n_st.r2;
        r_st.r3       <= n_st.r3;
    end

    assign o_st = r_st;

endmodule

FILE: design/fixed_point_cube_root.sv
// Top level of the signed fixed-point cube root, one root bit per pipeline stage.
// Depends on fpcr_pkg and fpcr_stage.
//
//  Port group      Direction  Handshake
//  start, x_raw    in         word taken when start is high and busy is low
//  root, status    out        o_valid high for one cycle, always taken
//  cfg             in         i_cfg_we writes i_cfg_wdata at the clock edge
//
// A word enters every cycle; busy is always low.
// Each taken word passes through one input stage,
// one stage per root bit (22), and one output stage.
// Synchronous reset empties the pipeline and clears the configuration bit.
// The receiver cannot stall, so the pipeline never holds.
module fixed_point_cube_root (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [fpcr_pkg::DATA_BITS-1:0] i_x_raw,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_wdata,
    output logic                                o_valid,
    output logic signed [fpcr_pkg::DATA_BITS-1:0] o_root_raw,
    output logic [1:0]                          o_status
);
    import fpcr_pkg::*;

    localparam logic [DATA_BITS-1:0] SIGN = {1'b1, {(DATA_BITS-1){1'b0}}};
    localparam logic [DATA_BITS-1:0] FMAX = {1'b0, {(DATA_BITS-1){1'b1}}};

    logic                 r_spec;
    logic [DATA_BITS-1:0] t_x;
    logic [DATA_BITS-1:0] t_mag;
    logic [DATA_BITS-1:0] t_sat;
    logic [DATA_BITS-1:0] t_root;
    t_work                n_in;
    t_work                w [0:ROOT_BITS];
    logic                 n_valid;
    logic [DATA_BITS-1:0] n_root;
    logic [1:0]           n_status;
    logic                 r_valid;
    logic [DATA_BITS-1:0] r_root;
    logic [1:0]           r_status;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spec <= 1'b0;
        end else if (i_cfg_we) begin
            r_spec <= i_cfg_wdata;
        end
    end

    always_comb begin
        t_x          = i_x_raw;
        t_mag        = t_x[DATA_BITS-1] ? (~t_x + DATA_BITS'(1)) : t_x;
        n_in.valid   = start;
        n_in.neg     = t_x[DATA_BITS-1];
        n_in.pass    = 1'b0;
        n_in.status  = ST_OK;
        n_in.pass_val = t_x;
        n_in.n       = N_BITS'(t_mag) << (2 * SCALE_SHIFT);
        n_in.r       = '0;
        n_in.r2      = '0;
        n_in.r3      = '0;
        if (r_spec && t_x == SIGN) begin
            n_in.pass   = 1'b1;
            n_in.status = ST_NAN;
        end else if (r_spec && (t_x == FMAX || t_x == (~FMAX + DATA_BITS'(1)))) begin
            n_in.pass   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            w[0].valid <= 1'b0;
        end else begin
            w[0].valid <= n_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        w[0].pass     <= n_in.pass;
        w[0].neg      <= n_in.neg;
        w[0].status   <= n_in.status;
        w[0].pass_val <= n_in.pass_val;
        w[0].n        <= n_in.n;
        w[0].r        <= n_in.r;
        w[0].r2       <= n_in.r2;
        w[0].r3       <= n_in.r3;
    end

    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_bit
        fpcr_stage #(
            .BIT(ROOT_BITS - 1 - g)
        ) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_st   (w[g]),
            .o_st   (w[g+1])
        );
    end

    always_comb begin
        t_sat    = r_spec ? (FMAX - DATA_BITS'(1)) : FMAX;
        t_root   = DATA_BITS'(w[ROOT_BITS].r);
        n_valid  = w[ROOT_BITS].valid;
        n_status = ST_OK;
        if (w[ROOT_BITS].pass) begin
            n_root   = w[ROOT_BITS].pass_val;
            n_status = w[ROOT_BITS].status;
        end else if (t_root > t_sat) begin
            n_status = ST_OVF;
            if (w[ROOT_BITS].neg) begin
                n_root = r_spec ? (~t_sat + DATA_BITS'(1)) : SIGN;
            end else begin
                n_root = t_sat;
            end
        end else begin
            n_root = w[ROOT_BITS].neg ? (~t_root + DATA_BITS'(1)) : t_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root   <= n_root;
        r_status <= n_status;
    end

    assign o_valid    = r_valid;
    assign o_root_raw = r_root;
    assign o_status   = r_status;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##24 o_valid)
        else $error("Result did not appear at the pipeline latency.");

    a_nan_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_NAN) |-> (o_root_raw == SIGN && r_spec))
        else $error("NaN status without the NaN code.");

    a_ovf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OVF) |->
            (o_root_raw == FMAX || o_root_raw == SIGN
             || o_root_raw == FMAX - DATA_BITS'(1)
             || o_root_raw == SIGN + DATA_BITS'(2)))
        else $error("Saturated word is not a format limit.");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for fixed_point_cube_root: directed and random words,
// both settings of the special-values bit. Depends on fpcr_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;

    import fpcr_pkg::*;

    typedef struct packed {
        logic [DATA_BITS-1:0] root;
        logic [1:0]           status;
    } t_root_word;

    localparam logic [DATA_BITS-1:0] SIGN_CODE = 32'h8000_0000;
    localparam logic [DATA_BITS-1:0] FMAX_CODE = 32'h7fff_ffff;
    localparam int IDLE_LIMIT = 5000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic signed [DATA_BITS-1:0] i_x_raw;
    logic                        i_cfg_we;
    logic                        i_cfg_wdata;
    logic                        o_valid;
    logic signed [DATA_BITS-1:0] o_root_raw;
    logic [1:0]                  o_status;

    logic       specials_on;
    logic       gaps_on;
    int         error_count;
    int         idle_cycles;
    t_root_word expected_roots[$];

    fixed_point_cube_root u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_x_raw    (i_x_raw),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_valid    (o_valid),
        .o_root_raw (o_root_raw),
        .o_status   (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Truncated signed cube root of x / 65536, built one root bit at a time.
    function automatic t_root_word cube_root_of(logic [DATA_BITS-1:0] x, logic spec);
        t_root_word           res;
        logic [DATA_BITS-1:0] sat;
        logic [32:0]          mag;
        logic [127:0]         n;
        logic [127:0]         cand;
        logic [127:0]         cube;
        logic [127:0]         root;
        logic                 neg;
        neg = x[DATA_BITS-1];
        sat = FMAX_CODE;
        if (spec) begin
            if (x == SIGN_CODE) begin
                res.root = SIGN_CODE;
                res.status = ST_NAN;
                return res;
            end
            if (x == FMAX_CODE || x == -FMAX_CODE) begin
                res.root = x;
                res.status = ST_OK;
                return res;
            end
            sat = FMAX_CODE - 1;
        end
        if (x == '0) begin
            res.root = '0;
            res.status = ST_OK;
            return res;
        end
        mag = neg ? (33'h1_0000_0000 - {1'b0, x}) : {1'b0, x};
        n = {95'd0, mag} << 32;
        root = '0;
        for (int i = 23; i >= 0; i--) begin
            cand = root | (128'd1 << i);
            cube = cand * cand * cand;
            if (cube <= n) begin
                root = cand;
            end
        end
        if (root > {96'd0, sat}) begin
            res.root = neg ? (spec ? -sat : SIGN_CODE) : sat;
            res.status = ST_OVF;
        end else begin
            res.root = neg ? -root[DATA_BITS-1:0] : root[DATA_BITS-1:0];
            res.status = ST_OK;
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (!gaps_on || roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 5);
    endfunction

    task automatic send_word(logic [DATA_BITS-1:0] x);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_x_raw <= x;
        forever begin
            @(negedge i_clk);
            if (!busy) begin
                break;
            end
        end
        @(posedge i_clk);
        expected_roots.push_back(cube_root_of(x, specials_on));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_roots.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 6) @(posedge i_clk);
    endtask

    task automatic write_specials(logic v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        specials_on = v;
    endtask

    function automatic logic [DATA_BITS-1:0] random_operand();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45) begin
            return $urandom();
        end else if (roll < 65) begin
            return $urandom_range(200000) - 100000;
        end else if (roll < 75) begin
            return (32'd1 << $urandom_range(31)) ^ {32{$urandom_range(1) == 1}};
        end else if (roll < 85) begin
            return ($urandom_range(1290) ** 3) * ($urandom_range(1) ? 1 : -1);
        end
        case ($urandom_range(5))
            0: return SIGN_CODE;
            1: return FMAX_CODE;
            2: return -FMAX_CODE;
            3: return 32'd0;
            4: return 32'd1;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    task automatic test_directed_plain();
        logic [DATA_BITS-1:0] vals[12];
        vals = '{32'd0, 32'd1, 32'hffff_ffff, FMAX_CODE, SIGN_CODE, 32'h8000_0001,
                 32'd65536, -32'sd65536, 32'd524288, 32'd1769472, 32'h5555_5555,
                 32'haaaa_aaaa};
        write_specials(1'b0);
        foreach (vals[i]) send_word(vals[i]);
    endtask

    task automatic test_directed_specials();
        logic [DATA_BITS-1:0] vals[8];
        vals = '{SIGN_CODE, FMAX_CODE, 32'h8000_0001, 32'd0, 32'h7fff_fffe,
                 32'h8000_0002, 32'd1, 32'hffff_ffff};
        write_specials(1'b1);
        foreach (vals[i]) send_word(vals[i]);
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 6; phase++) begin
            write_specials(phase[0]);
            gaps_on = (phase != 2);
            repeat (240) send_word(random_operand());
        end
        gaps_on = 1'b1;
    endtask

    always @(negedge i_clk) begin
        t_root_word want;
        if (i_rst_n && o_valid) begin
            if (expected_roots.size() == 0) begin
                $display("%0t: unexpected result root %h status %0d",
                         $time, o_root_raw, o_status);
                error_count++;
            end else begin
                want = expected_roots.pop_front();
                if (o_root_raw !== want.root) begin
                    $display("%0t: root expected %h actual %h", $time, want.root, o_root_raw);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || i_cfg_we || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_x_raw = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        specials_on = 1'b0;
        gaps_on = 1'b1;
        error_count = 0;
        idle_cycles = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_plain();
        test_directed_specials();
        test_random();
        drain();
        if (error_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
